// ----- rtl/core/wsm_pkg.sv -----
// shared types and constants of the window slot mapper
package wsm_pkg;

	// slot and table index width (table of 512 entries)
	localparam int unsigned SLOT_W = 9;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned BASE_W = 52;
	localparam int unsigned FRAME_W = 44;
	localparam int unsigned PHYS_W = 56;
	localparam int unsigned VADDR_W = 64;

	localparam logic OP_MAP = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic               load;   // place the search token at cell slot
		logic               free;   // free cell slot
		logic [SLOT_W-1:0]  slot;
		logic [FRAME_W-1:0] frame;  // frame number written by a claim
	} cell_cmd_t;

endpackage

// ----- rtl/core/wsm_cell.sv -----
// one slot cell of the mapper chain: in-use bit, frame number and token stage
module wsm_cell #(
	parameter int unsigned IDX = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wsm_pkg::cell_cmd_t   cmd,
	input  logic                 tok_in,
	output logic                 tok_out,
	output logic                 hit,
	output logic                 used
);

	logic                        used_q;
	logic                        tok_q;
	logic [wsm_pkg::FRAME_W-1:0] frame_q;
	logic                        sel;

	assign sel     = (cmd.slot == wsm_pkg::SLOT_W'(IDX));
	assign hit     = tok_q & ~used_q;
	// token moves on past a slot that is taken
	assign tok_out = tok_q & used_q;
	assign used    = used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= (IDX == 0);
			tok_q  <= 1'b0;
		end else begin
			tok_q <= (cmd.load & sel) | tok_in;
			if (hit) begin
				used_q <= 1'b1;
			end else if (cmd.free && sel) begin
				used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			frame_q <= cmd.frame;
		end else if (cmd.free && sel) begin
			frame_q <= '0;
		end
	end

endmodule

// ----- rtl/core/window_slot_mapper_top.sv -----
// top level of the window slot mapper: controller, slot cell chain and output register
// Allocates page slots of a window of SLOTS consecutive table entries; slot 0 is
// reserved for the window's own table. A map transaction drops a search token
// into the cell chain at the search hint; the token walks one cell per cycle
// until it reaches a free slot, which it claims. A map whose hint already lies
// past the last slot goes straight to the done state; otherwise the walk of the
// token along the chain sets how long the map lasts. A release goes through the
// free state to the done state. The result goes to an output register, so the
// next transaction may be taken while a result still waits there. The window
// base page register is written through the cfg channel, which is always ready;
// the user must write it only while the block is idle; the block does not enforce it.
module window_slot_mapper_top #(
	parameter int unsigned SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [51:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [55:0] phys_addr,
	input  logic [63:0] release_addr,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] mapped_addr,
	output logic        ok
);

	localparam int unsigned SW = wsm_pkg::SLOT_W;
	localparam int unsigned PS = wsm_pkg::PAGE_SHIFT;

	// controller states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                   state_q;
	logic [wsm_pkg::BASE_W-1:0]   base_q;
	logic [SW-1:0]                hint_q;
	logic [SW-1:0]                pos_q;
	logic [SW-1:0]                rel_slot_q;
	logic                         rel_ok_q;
	logic [wsm_pkg::FRAME_W-1:0]  frame_q;
	logic [wsm_pkg::VADDR_W-1:0]  res_addr_q;
	logic                         res_ok_q;
	logic                         out_valid_q;
	logic [wsm_pkg::VADDR_W-1:0]  mapped_addr_q;
	logic                         ok_q;

	wsm_pkg::cell_cmd_t           cmd;
	logic [SLOTS:0]               tok_chain;
	logic [SLOTS-1:0]             hit_vec;
	logic [SLOTS-1:0]             used_vec;
	logic                         any_hit;
	logic                         accept;
	logic                         hint_past_end;
	logic [SW-1:0]                rel_slot;
	logic                         rel_ok;
	logic [wsm_pkg::BASE_W-1:0]   page_sum;
	logic                         out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid   = out_valid_q;
	assign mapped_addr = mapped_addr_q;
	assign ok          = ok_q;

	assign hint_past_end = (hint_q >= SW'(SLOTS));

	// release: table index of the address relative to the window's first index
	assign rel_slot = release_addr[PS +: SW] - base_q[SW-1:0];
	assign rel_ok   = (release_addr != '0) && (rel_slot != '0) && (rel_slot < SW'(SLOTS));

	// address of the slot the token sits on; wraps modulo 2^64
	assign page_sum = base_q + wsm_pkg::BASE_W'(pos_q);

	assign any_hit  = |hit_vec;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// command broadcast to the chain
	always_comb begin
		cmd.load  = 1'b0;
		cmd.free  = 1'b0;
		cmd.slot  = hint_q;
		cmd.frame = frame_q;
		if (state_q == ST_FREE) begin
			cmd.slot = rel_slot_q;
			cmd.free = rel_ok_q;
		end else if (accept && operation == wsm_pkg::OP_MAP && !hint_past_end) begin
			cmd.load = 1'b1;
		end
	end

	// slot cell chain; the token enters at the hint and leaves past the last slot
	assign tok_chain[0] = 1'b0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		wsm_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1]),
			.hit     (hit_vec[i]),
			.used    (used_vec[i])
		);
	end

	// window base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hint_q  <= SW'(1);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == wsm_pkg::OP_RELEASE) begin
							state_q <= ST_FREE;
						end else if (hint_past_end) begin
							// window full above the hint
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (any_hit) begin
						hint_q  <= pos_q + SW'(1);
						state_q <= ST_DONE;
					end else if (pos_q == SW'(SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_FREE: begin
					if (rel_ok_q && rel_slot_q < hint_q) begin
						hint_q <= rel_slot_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// transaction data and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q      <= hint_q;
			frame_q    <= phys_addr[PS +: wsm_pkg::FRAME_W];
			rel_slot_q <= rel_slot;
			rel_ok_q   <= rel_ok;
			res_addr_q <= '0;
			res_ok_q   <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			pos_q <= pos_q + SW'(1);
			if (any_hit) begin
				res_addr_q <= {page_sum, {PS{1'b0}}};
				res_ok_q   <= 1'b1;
			end
		end else if (state_q == ST_FREE) begin
			res_ok_q <= rel_ok_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mapped_addr_q <= res_addr_q;
			ok_q          <= res_ok_q;
		end
	end

`ifndef SYNTHESIS
	// at most one cell claims in a cycle
	a_single_claim: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one slot claimed in a cycle");

	// the reserved slot stays in use
	a_reserved_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_vec[0])
		else $error("reserved slot marked free");

	// the hint never points past one beyond the last slot
	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= SW'(SLOTS))
		else $error("search hint out of range");

	// a claim only happens while scanning
	a_claim_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		any_hit |-> state_q == ST_SCAN)
		else $error("slot claimed outside of a scan");

	// a pending result is not overwritten before it is taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(mapped_addr_q) && $stable(ok_q))
		else $error("stalled result changed");
`endif

endmodule
